// File: hdl/assert_macros.svh
// Assertion helpers for the RTL. In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge, suspended while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// File: hdl/ffc_pkg.sv
package ffc_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = $clog2(DATA_W);
  localparam logic [3:0]  MAX_DIGIT = 4'd9;

  typedef enum logic [2:0] {
    KEY_DIGIT  = 3'd0,
    KEY_ADD    = 3'd1,
    KEY_SUB    = 3'd2,
    KEY_MUL    = 3'd3,
    KEY_DIV    = 3'd4,
    KEY_EQUALS = 3'd5,
    KEY_CLEAR  = 3'd6
  } key_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_OP     = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DIV_ZERO = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_MUL,
    FSM_DIV_ABS_X,
    FSM_DIV_ABS_Y,
    FSM_DIV,
    FSM_DIV_SIGN,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] digit;
  } calc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] display_value;
    logic [1:0]               status;
  } calc_out_t;

  // Operator keys map onto the stored operator code in key order.
  function automatic op_e key_to_op(input key_e key);
    logic [1:0] code;
    code = key[1:0] - 2'd1;
    return op_e'(code);
  endfunction

endpackage

// File: hdl/four_function_calculator_keys.sv
// Immediate-execution four-function calculator driven by key presses.
//
// Input channel: one item per key (action and digit). Output channel: one item
// per key, carrying the displayed value and a status code (ok, division by
// zero, digit dropped on overflow). Both channels use valid and stall; an item
// moves on a rising edge with valid high and stall low.
//
// Digits, clear, add, subtract, a division by zero and keys that cause no
// evaluation finish in the cycle they are accepted; the result sits in the
// output register in the next cycle. A multiply runs 64 shift-and-add steps,
// and a divide by a nonzero value takes two magnitude steps, 64 restoring
// steps and a sign step. All of these steps share one 65-bit adder, which
// sets the latency.
// While a multiply or divide runs, the input is stalled.
//
// When the receiver stalls, the result waits in the output register and the
// input is stalled until it leaves, so no item is dropped.
//
// Reset clears both operands, the pending operator (add), the entry phase and
// the output valid flag; the block takes a key in the first cycle after reset.
module four_function_calculator_keys (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffc_pkg::calc_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffc_pkg::calc_out_t out_item_o
);
  import ffc_pkg::*;

  `include "assert_macros.svh"

  // Architectural calculator state.
  logic [DATA_W-1:0] first_q, first_d;
  logic [DATA_W-1:0] second_q, second_d;
  op_e               op_q, op_d;
  phase_e            phase_q, phase_d;

  // Sequencer and shared-unit working registers.
  fsm_e              state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;   // accumulator for multiply, remainder for divide
  logic [DATA_W-1:0] quo_q, quo_d;   // multiplier for multiply, dividend/quotient for divide
  logic [DATA_W-1:0] b_q, b_d;       // multiplicand for multiply, divisor for divide
  logic [DATA_W-1:0] res_q, res_d;
  logic              neg_q, neg_d;
  key_e              key_q, key_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  calc_out_t         out_item_q, out_item_d;

  key_e              key;
  logic              accept;
  logic              out_free;
  logic              eval_req;
  logic              start_mul;
  logic              start_div;
  logic              last_step;

  // Shared adder. Subtraction is a + ~b + 1, and the top sum bit is the
  // carry, which reads as "a >= b" for a subtraction.
  logic [DATA_W:0]   alu_a, alu_b;
  logic              alu_sub;
  logic [DATA_W+1:0] alu_sum;

  // Digit append: value*10 plus or minus the digit, with a range check.
  logic [DATA_W-1:0] cur_opnd;
  logic [DATA_W+3:0] cur_ext, times10, dig_ext, app_wide;
  logic [DATA_W-1:0] app_val;
  logic              app_ovf;
  logic [DATA_W-1:0] mul_next;

  assign key       = key_e'(in_item_i.action);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != FSM_IDLE) || !out_free;
  assign accept    = in_valid_i && !in_stall_o;
  assign last_step = (cnt_q == {CNT_W{1'b1}});

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An operator or equals key in the second-operand phase evaluates the
  // expression. Multiply and a divide by a nonzero value go to the sequencer.
  always_comb begin
    eval_req  = accept && (phase_q == PH_SECOND) &&
                (key inside {[KEY_ADD:KEY_EQUALS]});
    start_mul = eval_req && (op_q == OP_MUL);
    start_div = eval_req && (op_q == OP_DIV) && (second_q != '0);
  end

  always_comb begin
    alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
              {{(DATA_W+1){1'b0}}, alu_sub};
  end

  always_comb begin
    cur_opnd = (phase_q == PH_SECOND) ? second_q : first_q;
    cur_ext  = {{4{cur_opnd[DATA_W-1]}}, cur_opnd};
    times10  = (cur_ext << 3) + (cur_ext << 1);
    dig_ext  = {{DATA_W{1'b0}}, in_item_i.digit};
    app_wide = cur_opnd[DATA_W-1] ? (times10 - dig_ext) : (times10 + dig_ext);
    if (cur_opnd == '0) begin
      app_val = {{(DATA_W-4){1'b0}}, in_item_i.digit};
      app_ovf = 1'b0;
    end else begin
      app_val = app_wide[DATA_W-1:0];
      // The result fits only if the top bits are all copies of the sign bit.
      app_ovf = !((&app_wide[DATA_W+3:DATA_W-1]) || !(|app_wide[DATA_W+3:DATA_W-1]));
    end
  end

  // Operand selection for the shared adder in each sequencer state.
  always_comb begin
    alu_a   = {1'b0, first_q};
    alu_b   = {1'b0, second_q};
    alu_sub = (op_q == OP_SUB);
    case (state_q)
      FSM_IDLE: begin
        alu_a   = {1'b0, first_q};
        alu_b   = {1'b0, second_q};
        alu_sub = (op_q == OP_SUB);
      end
      FSM_MUL: begin
        alu_a   = {1'b0, rem_q};
        alu_b   = {1'b0, b_q};
        alu_sub = 1'b0;
      end
      FSM_DIV_ABS_X: begin
        alu_a   = '0;
        alu_b   = {1'b0, first_q};
        alu_sub = 1'b1;
      end
      FSM_DIV_ABS_Y: begin
        alu_a   = '0;
        alu_b   = {1'b0, second_q};
        alu_sub = 1'b1;
      end
      FSM_DIV: begin
        alu_a   = {rem_q, quo_q[DATA_W-1]};
        alu_b   = {1'b0, b_q};
        alu_sub = 1'b1;
      end
      FSM_DIV_SIGN: begin
        alu_a   = '0;
        alu_b   = {1'b0, quo_q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = {1'b0, first_q};
        alu_b   = {1'b0, second_q};
        alu_sub = 1'b0;
      end
    endcase
  end

  assign mul_next = quo_q[0] ? alu_sum[DATA_W-1:0] : rem_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (start_mul) begin
          state_d = FSM_MUL;
        end else if (start_div) begin
          state_d = FSM_DIV_ABS_X;
        end
      end
      FSM_MUL: begin
        if (last_step) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_DIV_ABS_X: state_d = FSM_DIV_ABS_Y;
      FSM_DIV_ABS_Y: state_d = FSM_DIV;
      FSM_DIV: begin
        if (last_step) begin
          state_d = FSM_DIV_SIGN;
        end
      end
      FSM_DIV_SIGN: state_d = FSM_FINISH;
      FSM_FINISH: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    logic    write_out;
    status_e stat;

    first_d     = first_q;
    second_d    = second_q;
    op_d        = op_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    b_d         = b_q;
    res_d       = res_q;
    neg_d       = neg_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    write_out   = 1'b0;
    stat        = STAT_OK;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          write_out = !(start_mul || start_div);
          key_d     = key;
          cnt_d     = '0;
          rem_d     = '0;
          b_d       = first_q;
          quo_d     = second_q;
          neg_d     = first_q[DATA_W-1] ^ second_q[DATA_W-1];
          case (key)
            KEY_DIGIT: begin
              if (in_item_i.digit <= MAX_DIGIT) begin
                if (phase_q == PH_OP) begin
                  second_d = {{(DATA_W-4){1'b0}}, in_item_i.digit};
                  phase_d  = PH_SECOND;
                end else if (app_ovf) begin
                  stat = STAT_OVERFLOW;
                end else if (phase_q == PH_SECOND) begin
                  second_d = app_val;
                end else begin
                  first_d = app_val;
                end
              end
            end
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQUALS: begin
              if (phase_q == PH_SECOND) begin
                if (op_q == OP_ADD || op_q == OP_SUB) begin
                  first_d  = alu_sum[DATA_W-1:0];
                  second_d = '0;
                end else if (op_q == OP_DIV && second_q == '0) begin
                  first_d  = '0;
                  second_d = '0;
                  stat     = STAT_DIV_ZERO;
                end
                if (!(start_mul || start_div)) begin
                  if (key == KEY_EQUALS) begin
                    phase_d = PH_FIRST;
                  end else begin
                    op_d    = key_to_op(key);
                    phase_d = PH_OP;
                  end
                end
              end else if (phase_q != PH_OP && key != KEY_EQUALS) begin
                op_d    = key_to_op(key);
                phase_d = PH_OP;
              end
            end
            KEY_CLEAR: begin
              first_d  = '0;
              second_d = '0;
              op_d     = OP_ADD;
              phase_d  = PH_FIRST;
            end
            default: begin
            end
          endcase
        end
      end
      FSM_MUL: begin
        rem_d = mul_next;
        b_d   = b_q << 1;
        quo_d = quo_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          res_d = mul_next;
        end
      end
      FSM_DIV_ABS_X: begin
        quo_d = first_q[DATA_W-1] ? alu_sum[DATA_W-1:0] : first_q;
      end
      FSM_DIV_ABS_Y: begin
        b_d = second_q[DATA_W-1] ? alu_sum[DATA_W-1:0] : second_q;
      end
      FSM_DIV: begin
        // Restoring step: keep the difference when the shifted remainder
        // reaches the divisor, and shift the quotient bit in from the right.
        rem_d = alu_sum[DATA_W+1] ? alu_sum[DATA_W-1:0]
                                  : {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], alu_sum[DATA_W+1]};
        cnt_d = cnt_q + 1'b1;
      end
      FSM_DIV_SIGN: begin
        res_d = neg_q ? alu_sum[DATA_W-1:0] : quo_q;
      end
      FSM_FINISH: begin
        if (out_free) begin
          write_out = 1'b1;
          first_d   = res_q;
          second_d  = '0;
          if (key_q == KEY_EQUALS) begin
            phase_d = PH_FIRST;
          end else begin
            op_d    = key_to_op(key_q);
            phase_d = PH_OP;
          end
        end
      end
      default: begin
      end
    endcase

    if (write_out) begin
      out_valid_d              = 1'b1;
      out_item_d.display_value = (phase_d == PH_SECOND) ? second_d : first_d;
      out_item_d.status        = stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      first_q     <= '0;
      second_q    <= '0;
      op_q        <= OP_ADD;
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      second_q    <= second_d;
      op_q        <= op_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    b_q        <= b_d;
    res_q      <= res_d;
    neg_q      <= neg_d;
    key_q      <= key_d;
    out_item_q <= out_item_d;
  end

  // The second operand is only nonzero while it is being entered.
  `ASSERT_CLK(a_second_zero, (phase_q != PH_SECOND) |-> (second_q == '0), "second operand not cleared")
  // A finished evaluation with a free output register delivers and returns to idle.
  `ASSERT_CLK(a_finish_done, (state_q == FSM_FINISH && !out_valid_q) |=> (out_valid_q && state_q == FSM_IDLE), "finish did not deliver")
  // The last restoring step hands over to the sign correction.
  `ASSERT_CLK(a_div_sign, (state_q == FSM_DIV && last_step) |=> (state_q == FSM_DIV_SIGN), "divide did not end after 64 steps")
  // A multiply stays in its loop until the finish state.
  `ASSERT_CLK(a_mul_loop, (state_q == FSM_MUL) |=> (state_q == FSM_MUL || state_q == FSM_FINISH), "multiply left its loop")

endmodule

// File: verif/testbench.sv
// Self-checking bench for the key-driven calculator. A queue of keys, filled
// once at time zero, feeds a clocked driver. Every key the block accepts is run
// through a behavioral copy of the calculator kept inside this module. That copy
// works out the display value and status the block must return for the key.
// A clocked monitor takes each returned item and compares it with the oldest
// value still waiting.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffc_pkg::*;

  // The action field is three bits wide, so one code is left without a key.
  // The block must ignore it and report ok.
  localparam logic [2:0] KEY_UNUSED = 3'd7;

  localparam longint SIGNED_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SIGNED_MIN = 64'sh8000_0000_0000_0000;

  localparam int IDLE_PCT    = 33;
  // Both sides run without idling while this many items are counted.
  localparam int QUIET_LO    = 300;
  localparam int QUIET_HI    = 450;
  localparam int RANDOM_KEYS = 1050;
  // The tail wait covers one full divide and more.
  localparam int TAIL_CYCLES = 100;
  // The worst correct run is about 1100 keys, each up to a full divide, plus gaps.
  // The limit is several times that.
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    calc_out_t   res;
    int unsigned cyc;   // cycle on which the key behind this result was accepted
  } display_due_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  calc_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  calc_out_t out_item;

  calc_in_t     key_queue[$];
  display_due_t display_due_q[$];
  display_due_t drv_due;
  display_due_t mon_due;

  // Calculator state as the block should hold it.
  longint acc_q;      // first operand, and the last result
  longint arg_q;      // second operand
  op_e    op_q;
  phase_e phase_q;

  int unsigned cycle = 0;
  int unsigned keys_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned directed_keys = 0;
  int unsigned mul_cnt = 0;
  int unsigned div_cnt = 0;
  int unsigned div_zero_cnt = 0;
  int unsigned overflow_cnt = 0;

  four_function_calculator_keys i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calculator model
  // ---------------------------------------------------------------------------

  // Appends one decimal digit to an operand. A zero operand is replaced by the
  // digit. A positive operand grows as v*10+d and a negative one as v*10-d.
  // If the new value would leave the signed 64-bit range, the operand is kept
  // and ok is cleared.
  task automatic append_digit(inout longint v, input logic [3:0] d, output bit ok);
    longint dl;
    dl = {60'd0, d};
    ok = 1'b1;
    if (v == 0) begin
      v = dl;
    end else if (v > 0) begin
      if (v > (SIGNED_MAX - dl) / 10) ok = 1'b0;
      else v = v * 10 + dl;
    end else begin
      if (v < (SIGNED_MIN + dl) / 10) ok = 1'b0;
      else v = v * 10 - dl;
    end
  endtask

  // Applies the pending operator to both operands. The result replaces the
  // first operand and the second operand is cleared.
  function automatic status_e finish_expression();
    status_e st = STAT_OK;
    case (op_q)
      OP_ADD: acc_q = acc_q + arg_q;
      OP_SUB: acc_q = acc_q - arg_q;
      OP_MUL: begin
        acc_q = acc_q * arg_q;
        mul_cnt++;
      end
      default: begin
        div_cnt++;
        // A zero divisor gives 0 and a status. The most negative value divided
        // by minus one wraps back to itself, so the first operand is kept.
        if (arg_q == 0) begin
          acc_q = 0;
          st = STAT_DIV_ZERO;
          div_zero_cnt++;
        end else if (!(acc_q == SIGNED_MIN && arg_q == -1)) begin
          acc_q = acc_q / arg_q;
        end
      end
    endcase
    arg_q = 0;
    return st;
  endfunction

  // Applies one key to the model state and returns the item the block must show.
  task automatic press_key(input calc_in_t key, output calc_out_t res);
    status_e st;
    bit      ok;
    st = STAT_OK;
    ok = 1'b1;
    case (key.action)
      KEY_DIGIT: begin
        // Digit codes above nine are ignored and the status stays ok.
        if (key.digit <= MAX_DIGIT) begin
          if (phase_q == PH_OP) begin
            arg_q = {60'd0, key.digit};
            phase_q = PH_SECOND;
          end else if (phase_q == PH_SECOND) begin
            append_digit(arg_q, key.digit, ok);
          end else begin
            append_digit(acc_q, key.digit, ok);
          end
          if (!ok) begin
            st = STAT_OVERFLOW;
            overflow_cnt++;
          end
        end
      end
      KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
        // An operator right after another operator is ignored.
        if (phase_q != PH_OP) begin
          if (phase_q == PH_SECOND) st = finish_expression();
          case (key.action)
            KEY_ADD: op_q = OP_ADD;
            KEY_SUB: op_q = OP_SUB;
            KEY_MUL: op_q = OP_MUL;
            default: op_q = OP_DIV;
          endcase
          phase_q = PH_OP;
        end
      end
      KEY_EQUALS: begin
        // Equals only acts when a second operand is being entered.
        if (phase_q == PH_SECOND) begin
          st = finish_expression();
          phase_q = PH_FIRST;
        end
      end
      KEY_CLEAR: begin
        acc_q = 0;
        arg_q = 0;
        op_q = OP_ADD;
        phase_q = PH_FIRST;
      end
      default: ;
    endcase
    res.display_value = (phase_q == PH_SECOND) ? arg_q : acc_q;
    res.status = st;
  endtask

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Key sequences
  // ---------------------------------------------------------------------------

  task automatic push_key(input logic [2:0] action, input logic [3:0] digit);
    calc_in_t k;
    k.action = action;
    k.digit = digit;
    key_queue.push_back(k);
  endtask

  // On keys other than digits, the digit field carries random junk that the
  // block must ignore.
  task automatic push_op(input logic [2:0] action);
    push_key(action, 4'($urandom_range(15)));
  endtask

  task automatic push_digits(input string s);
    for (int i = 0; i < s.len(); i++) push_key(KEY_DIGIT, 4'(s.getc(i) - 8'd48));
  endtask

  task automatic push_number(input int max_len);
    int len;
    len = $urandom_range(max_len, 1);
    repeat (len) push_key(KEY_DIGIT, 4'($urandom_range(9)));
  endtask

  // One arithmetic expression with random content. It may start from the
  // previous result and may end without equals, so that the next expression
  // chains onto it. Long first operands sometimes run into the overflow check.
  task automatic push_expression();
    int n_ops;
    if ($urandom_range(3) == 0) push_op(KEY_CLEAR);
    if ($urandom_range(2) != 0) push_number(($urandom_range(9) == 0) ? 21 : 8);
    n_ops = $urandom_range(3, 1);
    repeat (n_ops) begin
      push_op(3'($urandom_range(KEY_DIV, KEY_ADD)));
      if ($urandom_range(9) == 0) push_op(3'($urandom_range(KEY_DIV, KEY_ADD)));
      // Second operands are often one to three digits, and sometimes a lone zero.
      if ($urandom_range(9) == 0) push_key(KEY_DIGIT, 4'd0);
      else push_number(($urandom_range(4) == 0) ? 12 : 3);
    end
    if ($urandom_range(4) != 0) push_op(KEY_EQUALS);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers keys from the queue. It idles at random, except in a quiet
  // window. It also holds back at two points until every result is back.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        press_key(in_item, drv_due.res);
        drv_due.cyc = cycle;
        display_due_q.push_back(drv_due);
        keys_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (key_queue.size() == 0 ||
            ((keys_sent == directed_keys || keys_sent == 600) &&
             display_due_q.size() != 0) ||
            (!(keys_sent >= QUIET_LO && keys_sent < QUIET_HI) &&
             $urandom_range(99) < IDLE_PCT)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_item <= key_queue.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest expected one.
  // An expectation made on this same edge belongs to a key accepted just now.
  // Its result cannot leave yet, so an output item matched against it is
  // reported as unexpected.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (display_due_q.size() == 0 || display_due_q[0].cyc == cycle) begin
          note_failure($sformatf("unexpected result display=%0d status=%0d",
                                 out_item.display_value, out_item.status));
        end else begin
          mon_due = display_due_q.pop_front();
          if (out_item.display_value !== mon_due.res.display_value ||
              out_item.status !== mon_due.res.status) begin
            note_failure($sformatf("result %0d: display exp %0d got %0d, status exp %0d got %0d",
                                   results_seen, mon_due.res.display_value,
                                   out_item.display_value, mon_due.res.status,
                                   out_item.status));
          end
        end
      end
      out_stall <= !(results_seen >= QUIET_LO && results_seen < QUIET_HI) &&
                   ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Cycle count and the watchdog for a block that hangs.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle,
               display_due_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int sel;
    acc_q = 0;
    arg_q = 0;
    op_q = OP_ADD;
    phase_q = PH_FIRST;

    // Directed keys. Equals and a repeated operator come where nothing is
    // pending. Ignored digit and action codes, each operator, a zero divisor,
    // a negative result that takes more digits, and truncation toward zero.
    push_op(KEY_CLEAR);
    push_op(KEY_EQUALS);
    push_key(KEY_DIGIT, 4'd9);
    push_key(KEY_DIGIT, 4'd0);
    push_key(KEY_DIGIT, 4'd15);
    push_op(KEY_UNUSED);
    push_op(KEY_SUB);
    push_op(KEY_MUL);
    push_op(KEY_EQUALS);
    push_key(KEY_DIGIT, 4'd0);
    push_key(KEY_DIGIT, 4'd5);
    push_op(KEY_DIV);
    push_key(KEY_DIGIT, 4'd0);
    push_op(KEY_EQUALS);
    push_op(KEY_ADD);
    push_key(KEY_DIGIT, 4'd3);
    push_op(KEY_SUB);
    push_key(KEY_DIGIT, 4'd7);
    push_op(KEY_EQUALS);
    push_key(KEY_DIGIT, 4'd2);
    push_op(KEY_MUL);
    push_key(KEY_DIGIT, 4'd6);
    push_op(KEY_DIV);
    push_key(KEY_DIGIT, 4'd5);
    push_op(KEY_EQUALS);
    directed_keys = key_queue.size();

    // Random part. Most of it is well-formed expressions. Some of it walks an
    // operand up to either end of the signed range, and sometimes one digit past it.
    // The rest is random noise over every action and digit code.
    while (key_queue.size() < directed_keys + RANDOM_KEYS) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        push_op(KEY_CLEAR);
        push_digits("922337203685477580");
        push_number(2);
        if ($urandom_range(1) == 0) begin
          push_op(KEY_ADD);
          push_number(1);
          push_op(KEY_EQUALS);
        end
      end else if (sel < 10) begin
        // Makes -9, then appends digits toward the most negative value.
        push_op(KEY_CLEAR);
        push_digits("0");
        push_op(KEY_SUB);
        push_digits("9");
        push_op(KEY_EQUALS);
        push_digits("22337203685477580");
        push_number(2);
      end else if (sel < 20) begin
        repeat ($urandom_range(4, 1)) begin
          push_key(3'($urandom_range(KEY_UNUSED)), 4'($urandom_range(15)));
        end
      end else begin
        push_expression();
      end
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    while (key_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (display_due_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results for %0d keys (%0d directed) in %0d cycles.",
             results_seen, keys_sent, directed_keys, cycle);
    $display("Covered %0d multiplies, %0d divides, %0d by zero, %0d overflowing digits.",
             mul_cnt, div_cnt, div_zero_cnt, overflow_cnt);
    if (fail_cnt == 0 && display_due_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ffc_pkg.sv
hdl/four_function_calculator_keys.sv
verif/testbench.sv
